FILE: sv/qfte_pkg.sv
// ----------------------------------------------------------------------------
// qfte_pkg
// Shared types and constants for the quad/fan to triangle-list index expander.
// ----------------------------------------------------------------------------
package qfte_pkg;

  // Width of a vertex index inside the block; indices and the counter wrap here
  localparam int INDEX_BITS = 32;

  // Largest number of indices one vertex can release (a finished quad)
  localparam int BURST_MAX = 6;
  localparam int CNT_W     = $clog2(BURST_MAX + 1);
  localparam int PTR_W     = $clog2(BURST_MAX);

  // Primitive modes; any other code behaves as pass-through
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_QUAD = 2'd1;
  localparam logic [1:0] MODE_FAN  = 2'd2;

  // Index sources
  localparam logic SRC_COUNTER = 1'b0;
  localparam logic SRC_INPUT   = 1'b1;

  // Register select (address bit 2)
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_SOURCE = 1'b1;

  // Group positions
  localparam logic [1:0] POS_EMPTY = 2'd0;
  localparam logic [1:0] POS_ONE   = 2'd1;
  localparam logic [1:0] POS_TWO   = 2'd2;
  localparam logic [1:0] POS_THREE = 2'd3;

  typedef logic [INDEX_BITS-1:0] idx_t;

  // Indices released by one vertex, in emission order
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    idx_t [BURST_MAX-1:0]      idx;
  } burst_t;

endpackage

FILE: sv/qfte_expand.sv
// ----------------------------------------------------------------------------
// qfte_expand
// Vertex state (group position, buffered vertices, index counter) and the
// combinational expansion of one vertex into a burst of triangle indices.
// ----------------------------------------------------------------------------
module qfte_expand (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [31:0]            index_value,
  input  logic                   last_in,
  input  logic [1:0]             mode,
  input  logic                   source,
  output qfte_pkg::burst_t       burst
);

  logic [1:0]     pos_r, pos_nxt;
  qfte_pkg::idx_t first_r, first_nxt;
  qfte_pkg::idx_t second_r, second_nxt;
  qfte_pkg::idx_t third_r, third_nxt;
  qfte_pkg::idx_t vcnt_r, vcnt_nxt;
  qfte_pkg::idx_t v;

  // Pick the vertex index for this transfer
  assign v = (source == qfte_pkg::SRC_INPUT) ?
             index_value[qfte_pkg::INDEX_BITS-1:0] : vcnt_r;

  // Expand the vertex and work out the next state
  always_comb begin
    pos_nxt    = pos_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    vcnt_nxt   = vcnt_r + 1'b1;
    burst.cnt  = '0;
    for (int i = 0; i < qfte_pkg::BURST_MAX; i++) begin
      burst.idx[i] = v;
    end

    case (mode)
      qfte_pkg::MODE_QUAD: begin
        case (pos_r)
          qfte_pkg::POS_EMPTY: begin
            first_nxt = v;
            pos_nxt   = qfte_pkg::POS_ONE;
          end
          qfte_pkg::POS_ONE: begin
            second_nxt = v;
            pos_nxt    = qfte_pkg::POS_TWO;
          end
          qfte_pkg::POS_TWO: begin
            third_nxt = v;
            pos_nxt   = qfte_pkg::POS_THREE;
          end
          default: begin
            // Fourth vertex closes the quad: two triangles
            burst.idx[0] = first_r;
            burst.idx[1] = second_r;
            burst.idx[2] = third_r;
            burst.idx[3] = third_r;
            burst.idx[4] = v;
            burst.idx[5] = first_r;
            burst.cnt    = qfte_pkg::CNT_W'(6);
            pos_nxt      = qfte_pkg::POS_EMPTY;
          end
        endcase
      end
      qfte_pkg::MODE_FAN: begin
        if (pos_r == qfte_pkg::POS_EMPTY) begin
          first_nxt = v;
          pos_nxt   = qfte_pkg::POS_ONE;
        end else if (pos_r == qfte_pkg::POS_ONE) begin
          second_nxt = v;
          pos_nxt    = qfte_pkg::POS_TWO;
        end else begin
          // Hub, previous, current; current becomes the previous
          burst.idx[0] = first_r;
          burst.idx[1] = second_r;
          burst.idx[2] = v;
          burst.cnt    = qfte_pkg::CNT_W'(3);
          second_nxt   = v;
          pos_nxt      = qfte_pkg::POS_TWO;
        end
      end
      default: begin
        burst.cnt = qfte_pkg::CNT_W'(1);
      end
    endcase

    // End of draw drops all state
    if (last_in) begin
      pos_nxt    = qfte_pkg::POS_EMPTY;
      first_nxt  = '0;
      second_nxt = '0;
      third_nxt  = '0;
      vcnt_nxt   = '0;
    end
  end

  // Advance the state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= qfte_pkg::POS_EMPTY;
      first_r  <= '0;
      second_r <= '0;
      third_r  <= '0;
      vcnt_r   <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      third_r  <= third_nxt;
      vcnt_r   <= vcnt_nxt;
    end
  end

endmodule

FILE: sv/qfte_burst.sv
// ----------------------------------------------------------------------------
// qfte_burst
// Holds one burst of indices and hands them one per cycle into the output
// register while it is empty or being read; takes the next burst as the last
// index of the current one leaves. A vertex that releases no indices passes
// straight through and leaves the held burst untouched.
// ----------------------------------------------------------------------------
module qfte_burst (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  qfte_pkg::burst_t       burst_in,
  output logic                   load_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output qfte_pkg::idx_t         out_index,
  output logic                   out_last
);

  qfte_pkg::burst_t               buf_r;
  logic [qfte_pkg::CNT_W-1:0]     cnt_r;
  logic [qfte_pkg::PTR_W-1:0]     ptr_r;
  logic                           out_valid_r;
  qfte_pkg::idx_t                 out_index_r;
  logic                           out_last_r;
  logic                           pending;
  logic                           move;
  logic                           final_idx;
  logic                           empty_in;
  logic                           take;

  assign pending    = (qfte_pkg::CNT_W'(ptr_r) != cnt_r);
  assign move       = pending && (!out_valid_r || out_ready);
  assign final_idx  = (qfte_pkg::CNT_W'(ptr_r) + 1'b1 == cnt_r);

  // An empty burst never occupies the stage
  assign empty_in   = (burst_in.cnt == '0);
  assign take       = load && !empty_in;
  assign load_ready = !pending || (move && final_idx) || empty_in;

  // Hold the burst and step through it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (take) begin
      cnt_r <= burst_in.cnt;
      ptr_r <= '0;
    end else if (move) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      buf_r <= burst_in;
    end
  end

  // Output register: fill on a move, drop after a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_index_r <= buf_r.idx[ptr_r];
      out_last_r  <= final_idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

endmodule

FILE: sv/quad_fan_to_triangle_index_expander_core.sv
// ----------------------------------------------------------------------------
// quad_fan_to_triangle_index_expander_core
// Turns a vertex stream (list, quads or triangle fan) into triangle-list
// indices, with indices taken from the input or from a per-draw counter.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Carries
//  in_       input      in_valid/in_ready  in_index_value, in_last_in
//  out_      output     out_valid/out_ready out_index_out, out_last_of_run
//  cfg (APB) input      psel/penable/pready primitive_mode @0, index_source @4
//
//  Indices leave one per cycle through the output register while out_ready
//  does not stall it. A vertex that releases indices (1 list, 3 fan, 6
//  closing a quad) is taken as the last index of the previous burst moves
//  out; one that releases none is taken even while a burst drains.
//  Reset is synchronous and active low.
//  A stalled out_ready holds the output register, then in_ready low for a
//  vertex that releases indices.
//
module quad_fan_to_triangle_index_expander_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_index_value,
  input  logic        in_last_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_index_out,
  output logic        out_last_of_run,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]        mode_r;
  logic              src_r;
  logic              accept;
  logic              cfg_wr;
  qfte_pkg::burst_t  burst;
  qfte_pkg::idx_t    out_idx;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qfte_pkg::MODE_PASS;
      src_r  <= qfte_pkg::SRC_INPUT;
    end else if (cfg_wr) begin
      case (paddr[2])
        qfte_pkg::REG_MODE:   mode_r <= pwdata[1:0];
        qfte_pkg::REG_SOURCE: src_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      qfte_pkg::REG_MODE:   prdata = {30'd0, mode_r};
      qfte_pkg::REG_SOURCE: prdata = {31'd0, src_r};
      default:              prdata = '0;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Vertex state and expansion
  qfte_expand u_expand (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .index_value (in_index_value),
    .last_in     (in_last_in),
    .mode        (mode_r),
    .source      (src_r),
    .burst       (burst)
  );

  // Burst hold and output register
  qfte_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .burst_in   (burst),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_index  (out_idx),
    .out_last   (out_last_of_run)
  );

  assign out_index_out = 32'(out_idx);

endmodule
